@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the radial hole-fill interpolator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`endif

@@ hw/rtl/rhfi_pkg.sv @@
// Package of the radial hole-fill interpolator: constants, types, ray table.
// No dependencies; used by rhfi_div and radial_hole_fill_interpolator.
package rhfi_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int RAY_COUNT      = 120;
  localparam int RAY_W          = 7;
  localparam int WEIGHT         = 10000;
  localparam int EDGE_COLOUR    = 128;
  localparam int DDW            = 32;   // dividend and quotient width
  localparam int DVW            = 21;   // divisor width
  localparam int STEP_W         = 16;   // ray step counter width

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [17:0] q16_t;
  typedef q16_t dir_tab_t [RAY_COUNT];

  typedef struct packed {
    logic             start;
    logic [DDW-1:0]   dividend;
    logic [DVW-1:0]   divisor;
  } div_req_t;

  // Q16 direction components, truncated toward zero, angle 3k * 3.14159 / 180.
  function automatic dir_tab_t build_dir(input logic want_sin);
    dir_tab_t tab;
    real      ang;
    for (int k = 0; k < RAY_COUNT; k++) begin
      ang = 3.0 * k * 3.14159 / 180.0;
      if (want_sin) tab[k] = 18'($rtoi($sin(ang) * 65536.0));
      else tab[k] = 18'($rtoi($cos(ang) * 65536.0));
    end
    return tab;
  endfunction

  localparam dir_tab_t DIR_COS = build_dir(1'b0);
  localparam dir_tab_t DIR_SIN = build_dir(1'b1);

endpackage

@@ hw/rtl/radial_hole_fill_interpolator.sv @@
// Channel   | Ports                                          | Handshake
// ----------+------------------------------------------------+-------------------------
// input     | in_operation, in_pos_x, in_pos_y, in_pixel_in  | start high, busy low
// result    | out_pixel_out, out_was_hole                    | out_strobe, one cycle
// config    | cfg_index, cfg_data                            | cfg_valid and cfg_ready
//
// After reset the image store is cleared one pixel a cycle, all MAX_WIDTH*MAX_HEIGHT
// pixels, with busy high. A write item is stored at the edge that accepts it and busy
// stays low. A query of a nonzero pixel is read into rdata_r, checked in ST_CHK and then
// registered as the result. A hole walks 120 rays through the single memory port
// (a ray step passes ST_POS and, inside the image, ST_TEST) and uses the shared divider
// twice per ray, and at the end if the weight sum is nonzero. The receiver cannot stall.
// Top level of the radial hole-fill interpolator; uses rhfi_pkg, rhfi_div and the macros.
`include "assert_macros.svh"
module radial_hole_fill_interpolator #(
  parameter int MAX_WIDTH  = rhfi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rhfi_pkg::DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_pixel_in,
  output logic       out_strobe,
  output logic [7:0] out_pixel_out,
  output logic       out_was_hole,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CHK   = 4'd2;
  localparam logic [3:0] ST_RAY   = 4'd3;
  localparam logic [3:0] ST_POS   = 4'd4;
  localparam logic [3:0] ST_TEST  = 4'd5;
  localparam logic [3:0] ST_DA    = 4'd6;
  localparam logic [3:0] ST_WA    = 4'd7;
  localparam logic [3:0] ST_WB    = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_WF    = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [8:0]  width_r, height_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [rhfi_pkg::RAY_W-1:0] k_r, k_nxt;
  logic signed [31:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [rhfi_pkg::STEP_W-1:0] t_r, t_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [31:0] num_r, num_nxt;
  logic [rhfi_pkg::DVW-1:0] den_r, den_nxt;
  logic        str_r, str_nxt, hole_r, hole_nxt;
  logic [7:0]  pix_r, pix_nxt;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata_r;
  logic        we;
  logic [AW-1:0] addr;
  logic [7:0]  wdata;

  logic [8:0]  w, h;
  logic        accept, in_inside;
  logic signed [31:0] nx, ny;
  logic        outside;
  logic [31:0] in_lin, ray_lin;

  rhfi_pkg::div_req_t  dreq;
  logic                ddone;
  logic [rhfi_pkg::DDW-1:0] dquot;

  rhfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quot  (dquot)
  );

  always_comb begin
    if (width_r == 9'd0) w = 9'd1;
    else if (32'(width_r) > MAX_WIDTH) w = 9'(MAX_WIDTH);
    else w = width_r;
    if (height_r == 9'd0) h = 9'd1;
    else if (32'(height_r) > MAX_HEIGHT) h = 9'(MAX_HEIGHT);
    else h = height_r;
  end

  assign accept    = start && !busy;
  assign in_inside = ({1'b0, in_pos_x} < w) && ({1'b0, in_pos_y} < h);
  assign in_lin    = 32'(in_pos_y) * 32'(MAX_WIDTH) + 32'(in_pos_x);

  // Ray point: the accumulators hold C*t and S*t, so the shift is the floor.
  assign nx      = $signed({24'd0, x_r}) + (ax_r >>> 16);
  assign ny      = $signed({24'd0, y_r}) + (ay_r >>> 16);
  assign outside = nx[31] || ny[31] || (nx >= $signed({23'd0, w})) ||
                   (ny >= $signed({23'd0, h}));
  assign ray_lin = ny * 32'(MAX_WIDTH) + nx;

  always_comb begin
    we    = 1'b0;
    wdata = in_pixel_in;
    addr  = in_lin[AW-1:0];
    if (state_r == ST_CLEAR) begin
      we    = 1'b1;
      wdata = '0;
      addr  = clr_r;
    end else if (state_r == ST_IDLE) begin
      we = accept && !in_operation && in_inside;
    end else begin
      addr = ray_lin[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    t_nxt     = t_r;
    col_nxt   = col_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    str_nxt   = 1'b0;
    hole_nxt  = hole_r;
    pix_nxt   = pix_r;
    dreq      = '0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        x_nxt = in_pos_x;
        y_nxt = in_pos_y;
        if (accept && in_operation && in_inside) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (rdata_r != 8'd0) begin
          str_nxt   = 1'b1;
          pix_nxt   = rdata_r;
          hole_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          num_nxt   = '0;
          den_nxt   = '0;
          k_nxt     = '0;
          state_nxt = ST_RAY;
        end
      end
      ST_RAY: begin
        ax_nxt    = 32'(rhfi_pkg::DIR_COS[k_r]);
        ay_nxt    = 32'(rhfi_pkg::DIR_SIN[k_r]);
        t_nxt     = 16'd1;
        state_nxt = ST_POS;
      end
      ST_POS: begin
        if (outside) begin
          col_nxt   = 8'(rhfi_pkg::EDGE_COLOUR);
          state_nxt = ST_DA;
        end else begin
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (rdata_r != 8'd0) begin
          col_nxt   = rdata_r;
          state_nxt = ST_DA;
        end else begin
          ax_nxt    = ax_r + 32'(rhfi_pkg::DIR_COS[k_r]);
          ay_nxt    = ay_r + 32'(rhfi_pkg::DIR_SIN[k_r]);
          t_nxt     = t_r + rhfi_pkg::STEP_W'(1);
          state_nxt = ST_POS;
        end
      end
      ST_DA: begin
        dreq.start    = 1'b1;
        dreq.dividend = 32'(col_r) * 32'(rhfi_pkg::WEIGHT);
        dreq.divisor  = rhfi_pkg::DVW'(t_r);
        state_nxt     = ST_WA;
      end
      ST_WA: begin
        if (ddone) begin
          num_nxt       = num_r + dquot;
          dreq.start    = 1'b1;
          dreq.dividend = 32'(rhfi_pkg::WEIGHT);
          dreq.divisor  = rhfi_pkg::DVW'(t_r);
          state_nxt     = ST_WB;
        end
      end
      ST_WB: begin
        if (ddone) begin
          den_nxt = den_r + dquot[rhfi_pkg::DVW-1:0];
          if (k_r == rhfi_pkg::RAY_W'(rhfi_pkg::RAY_COUNT - 1)) begin
            state_nxt = ST_FIN;
          end else begin
            k_nxt     = k_r + rhfi_pkg::RAY_W'(1);
            state_nxt = ST_RAY;
          end
        end
      end
      ST_FIN: begin
        if (den_r == '0) begin
          str_nxt   = 1'b1;
          pix_nxt   = 8'(rhfi_pkg::EDGE_COLOUR);
          hole_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = num_r;
          dreq.divisor  = den_r;
          state_nxt     = ST_WF;
        end
      end
      ST_WF: begin
        if (ddone) begin
          str_nxt   = 1'b1;
          pix_nxt   = (dquot[31:8] != '0) ? 8'hFF : dquot[7:0];
          hole_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      str_r    <= 1'b0;
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      str_r   <= str_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rhfi_pkg::REG_WIDTH) width_r <= cfg_data;
        else height_r <= cfg_data;
      end
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    t_r    <= t_nxt;
    col_r  <= col_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    hole_r <= hole_nxt;
    pix_r  <= pix_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_strobe    = str_r;
  assign out_pixel_out = pix_r;
  assign out_was_hole  = hole_r;

  // An in-range query always occupies the sequencer.
  `ASSERT_NEXT(a_query_busy, clk, rst_n, accept && in_operation && in_inside, busy)
  // At most one result per item: strobes never come back to back.
  `ASSERT_NEXT(a_single_result, clk, rst_n, out_strobe, !out_strobe)
  // A pixel returned as stored is never a hole.
  `ASSERT_NOW(a_stored_nonzero, clk, rst_n, out_strobe && !out_was_hole,
              out_pixel_out != 8'd0)
  // The divider only reports back while a hole is being filled.
  `ASSERT_NOW(a_div_in_fill, clk, rst_n, ddone,
              state_r == ST_WA || state_r == ST_WB || state_r == ST_WF)

endmodule

@@ hw/rtl/rhfi_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on rhfi_pkg.
module rhfi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rhfi_pkg::div_req_t        req,
  output logic                      done,
  output logic [rhfi_pkg::DDW-1:0]  quot
);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic [4:0]                cnt_r, cnt_nxt;
  logic [rhfi_pkg::DDW-1:0]  q_r, q_nxt;
  logic [rhfi_pkg::DVW-1:0]  rem_r, rem_nxt;
  logic [rhfi_pkg::DVW-1:0]  dvs_r, dvs_nxt;
  logic [rhfi_pkg::DVW:0]    sh;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    sh       = {rem_r, q_r[rhfi_pkg::DDW-1]};
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      q_nxt   = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (run_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = rhfi_pkg::DVW'(sh - {1'b0, dvs_r});
        q_nxt   = {q_r[rhfi_pkg::DDW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[rhfi_pkg::DVW-1:0];
        q_nxt   = {q_r[rhfi_pkg::DDW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(rhfi_pkg::DDW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for radial_hole_fill_interpolator: directed table, then random phases.
// Depends on rhfi_pkg and the block's RTL. Results are checked against an in-bench predictor.
`timescale 1ns / 1ps
module testbench;

  localparam int MAXW = 256;
  localparam int MAXH = 256;
  localparam int RAYS = 120;
  localparam longint CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [7:0] pix;
    logic       hole;
  } fill_result_t;

  typedef struct {
    logic       op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] pix;
    bit         typed;
    logic [7:0] exp_pix;
    logic       exp_hole;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = 1'b0;
  logic [7:0] in_pos_x = 8'd0;
  logic [7:0] in_pos_y = 8'd0;
  logic [7:0] in_pixel_in = 8'd0;
  logic       out_strobe;
  logic [7:0] out_pixel_out;
  logic       out_was_hole;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = rhfi_pkg::REG_WIDTH;
  logic [8:0] cfg_data = 9'd0;

  radial_hole_fill_interpolator uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state.
  logic [7:0]   pixel_mem [MAXW*MAXH];
  logic [8:0]   width_reg;
  logic [8:0]   height_reg;
  int           ray_cos [RAYS];
  int           ray_sin [RAYS];
  fill_result_t pending_fills [$];
  int           errors = 0;
  longint       cycles = 0;

  function automatic int clamp_dim(input logic [8:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Inverse-distance average over all rays; rays leaving the image count as grey 128.
  function automatic logic [7:0] fill_value(input int x, input int y, input int w, input int h);
    int unsigned num;
    int unsigned den;
    int unsigned colour;
    int unsigned avg;
    longint      t;
    longint      nx;
    longint      ny;
    num = 0;
    den = 0;
    for (int k = 0; k < RAYS; k++) begin
      t = 0;
      forever begin
        t++;
        nx = x + ((longint'(ray_cos[k]) * t) >>> 16);
        ny = y + ((longint'(ray_sin[k]) * t) >>> 16);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) begin
          colour = 128;
          break;
        end
        colour = 32'(pixel_mem[nx + ny * MAXW]);
        if (colour != 0) break;
      end
      num += (colour * 10000) / int'(t);
      den += 10000 / int'(t);
    end
    if (den == 0) return 8'd128;
    avg = num / den;
    return (avg > 255) ? 8'd255 : avg[7:0];
  endfunction

  function automatic void predict_item(input row_t r);
    int w;
    int h;
    fill_result_t res;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    if (int'(r.x) >= w || int'(r.y) >= h) return;
    if (!r.op) begin
      pixel_mem[int'(r.x) + int'(r.y) * MAXW] = r.pix;
      return;
    end
    if (pixel_mem[int'(r.x) + int'(r.y) * MAXW] != 0) begin
      res.pix = pixel_mem[int'(r.x) + int'(r.y) * MAXW];
      res.hole = 1'b0;
    end else begin
      res.pix = fill_value(int'(r.x), int'(r.y), w, h);
      res.hole = 1'b1;
    end
    if (r.typed) begin
      res.pix = r.exp_pix;
      res.hole = r.exp_hole;
    end
    pending_fills.push_back(res);
  endfunction

  always @(posedge clk) begin
    fill_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_fills.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: pixel %0d hole %0b", out_pixel_out,
                                   out_was_hole);
      end else begin
        e = pending_fills.pop_front();
        if (out_pixel_out !== e.pix || out_was_hole !== e.hole) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected pixel %0d hole %0b, got pixel %0d hole %0b",
                     e.pix, e.hole, out_pixel_out, out_was_hole);
        end
      end
    end
  end

  task automatic send_item(input row_t r, input bit allow_gap);
    start <= 1'b1;
    in_operation <= r.op;
    in_pos_x <= r.x;
    in_pos_y <= r.y;
    in_pixel_in <= r.pix;
    do @(posedge clk); while (busy);
    predict_item(r);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Let the block drain before a register is touched.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_fills.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rhfi_pkg::REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic row_t mk(input logic op, input int x, input int y, input int pix);
    row_t r;
    r.op = op;
    r.x = 8'(x);
    r.y = 8'(y);
    r.pix = 8'(pix);
    r.typed = 0;
    r.exp_pix = 8'd0;
    r.exp_hole = 1'b0;
    return r;
  endfunction

  function automatic row_t mk_exp(input int x, input int y, input int pix, input int ep);
    row_t r;
    r = mk(1'b1, x, y, pix);
    r.typed = 1;
    r.exp_pix = 8'(ep);
    r.exp_hole = 1'b0;
    return r;
  endfunction

  row_t       directed [$];
  logic [8:0] phase_w [6] = '{9'd0, 9'd16, 9'd511, 9'd24, 9'd256, 9'd12};
  logic [8:0] phase_h [6] = '{9'd0, 9'd16, 9'd4, 9'd40, 9'd1, 9'd9};

  initial begin
    row_t r;
    int   w;
    int   h;
    real  ang;
    for (int i = 0; i < MAXW*MAXH; i++) pixel_mem[i] = 8'd0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    for (int k = 0; k < RAYS; k++) begin
      ang = 3.0 * k * 3.14159 / 180.0;
      ray_cos[k] = $rtoi($cos(ang) * 65536.0);
      ray_sin[k] = $rtoi($sin(ang) * 65536.0);
    end

    directed.push_back(mk(1'b0, 255, 255, 255));
    directed.push_back(mk_exp(255, 255, 0, 255));
    directed.push_back(mk(1'b0, 0, 0, 1));
    directed.push_back(mk_exp(0, 0, 0, 1));
    directed.push_back(mk(1'b0, 0, 0, 0));
    directed.push_back(mk(1'b1, 0, 0, 0));
    directed.push_back(mk(1'b0, 128, 128, 77));
    directed.push_back(mk(1'b0, 130, 128, 90));
    directed.push_back(mk(1'b0, 128, 131, 30));
    directed.push_back(mk(1'b1, 129, 129, 0));
    directed.push_back(mk_exp(128, 128, 0, 77));
    // The pixel field of a query is ignored.
    directed.push_back(mk_exp(130, 128, 255, 90));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i], 1'b1);
    settle();

    for (int p = 0; p < 6; p++) begin
      write_reg(rhfi_pkg::REG_WIDTH, phase_w[p]);
      write_reg(rhfi_pkg::REG_HEIGHT, phase_h[p]);
      w = clamp_dim(phase_w[p], MAXW);
      h = clamp_dim(phase_h[p], MAXH);
      for (int i = 0; i < 24; i++) begin
        r = mk($urandom_range(0, 9) < 6 ? 1'b0 : 1'b1, 0, 0, 0);
        if ($urandom_range(0, 9) == 0) begin
          r.x = 8'($urandom_range(0, 255));
          r.y = 8'($urandom_range(0, 255));
        end else begin
          r.x = 8'($urandom_range(0, w - 1));
          r.y = 8'($urandom_range(0, h - 1));
        end
        r.pix = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_item(r, p != 5);
      end
      settle();
    end

    while (pending_fills.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rhfi_pkg.sv
hw/rtl/rhfi_div.sv
hw/rtl/radial_hole_fill_interpolator.sv
bench/testbench.sv
